>>> rtl/dqar_pkg.sv
// shared types, codes and constants for the dns query answer rewriter
// no dependencies; used by every module under rtl
package dqar_pkg;

	localparam int MAX_PACKET_BYTES = 512;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [9:0] COUNT_SAT = 10'd1023;
	localparam logic [7:0] LEN_PTR_MASK = 8'hC0;
	localparam logic [15:0] TYPE_A = 16'd1;
	localparam logic [15:0] TYPE_ANY = 16'd255;
	localparam logic [4:0] ANSWER_BYTES = 5'd16;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_PATCH = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_SHORT = 3'd1;
	localparam logic [2:0] ST_NO_QUESTION = 3'd2;
	localparam logic [2:0] ST_BAD_NAME = 3'd3;
	localparam logic [2:0] ST_TRUNCATED = 3'd4;
	localparam logic [2:0] ST_TOO_BIG = 3'd5;

	localparam logic [8:0] PATCH_OFFSET = 9'd7;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_LEN = 3'd1,
		PH_LABEL = 3'd2,
		PH_TAIL = 3'd3,
		PH_DONE = 3'd4,
		PH_STOP = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		STEP_DATA = 2'd0,
		STEP_PATCH = 2'd1,
		STEP_ANS = 2'd2,
		STEP_DONE = 2'd3
	} step_t;

	typedef struct packed {
		logic has_data;
		logic [8:0] data_off;
		logic [7:0] data_val;
		logic has_end;
		logic [2:0] status;
		logic ans;
		logic [9:0] qend;
		logic [9:0] resp_len;
	} job_t;

	function automatic logic [7:0] answer_byte(input logic [3:0] idx, input logic [31:0] addr);
		logic [7:0] v;
		unique case (idx)
			4'd0: v = 8'hC0;
			4'd1: v = 8'h0C;
			4'd3: v = 8'h01;
			4'd5: v = 8'h01;
			4'd9: v = 8'h3C;
			4'd11: v = 8'h04;
			4'd12: v = addr[31:24];
			4'd13: v = addr[23:16];
			4'd14: v = addr[15:8];
			4'd15: v = addr[7:0];
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/dqar_front.sv
// front part: accepts query bytes, parses header and first question
// builds at most one job per byte for the queue; uses dqar_pkg
module dqar_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       query_byte,
	input  logic             end_of_message,
	output logic             push,
	output dqar_pkg::job_t   job
);

	logic [9:0] byte_count_q;
	dqar_pkg::phase_t phase_q;
	logic [5:0] label_left_q;
	logic chn_q;
	logic [15:0] type_q;
	logic [9:0] qend_q;
	logic [2:0] fault_q;

	dqar_pkg::phase_t ph, ph_n;
	logic [2:0] flt;
	logic [5:0] ll_n;
	logic chn_n;
	logic [15:0] type_n;
	logic [9:0] qend_n;
	logic [9:0] n;
	logic over;
	logic ans_ok;
	logic [10:0] sum;
	logic [7:0] dval;

	always_comb begin
		over = (phase_q == dqar_pkg::PH_LEN || phase_q == dqar_pkg::PH_LABEL ||
			phase_q == dqar_pkg::PH_TAIL) &&
			({1'b0, byte_count_q} >= 11'(dqar_pkg::MAX_PACKET_BYTES));
		ph = over ? dqar_pkg::PH_STOP : phase_q;
		flt = over ? dqar_pkg::ST_TOO_BIG : fault_q;

		dval = query_byte;
		if (byte_count_q == 10'd2)
			dval = 8'h81;
		else if (byte_count_q == 10'd3)
			dval = 8'h80;
		else if (byte_count_q >= 10'd6 && byte_count_q < 10'd12)
			dval = 8'h00;

		ph_n = ph;
		ll_n = label_left_q;
		chn_n = chn_q;
		type_n = type_q;
		qend_n = qend_q;
		unique case (ph)
			dqar_pkg::PH_HEADER: begin
				if (byte_count_q == 10'd4) begin
					chn_n = (query_byte != 8'd0);
				end else if (byte_count_q == 10'd5) begin
					if (!chn_q && query_byte == 8'd0) begin
						flt = dqar_pkg::ST_NO_QUESTION;
						ph_n = dqar_pkg::PH_STOP;
					end
				end else if (byte_count_q == 10'd11) begin
					ph_n = dqar_pkg::PH_LEN;
				end
			end
			dqar_pkg::PH_LEN: begin
				if (query_byte == 8'd0) begin
					ll_n = 6'd4;
					ph_n = dqar_pkg::PH_TAIL;
				end else if ((query_byte & dqar_pkg::LEN_PTR_MASK) != 8'd0) begin
					flt = dqar_pkg::ST_BAD_NAME;
					ph_n = dqar_pkg::PH_STOP;
				end else begin
					ll_n = query_byte[5:0];
					ph_n = dqar_pkg::PH_LABEL;
				end
			end
			dqar_pkg::PH_LABEL: begin
				ll_n = label_left_q - 6'd1;
				if (ll_n == 6'd0)
					ph_n = dqar_pkg::PH_LEN;
			end
			dqar_pkg::PH_TAIL: begin
				if (label_left_q == 6'd4)
					type_n = {query_byte, 8'h00};
				else if (label_left_q == 6'd3)
					type_n = {type_q[15:8], query_byte};
				ll_n = label_left_q - 6'd1;
				if (ll_n == 6'd0) begin
					qend_n = byte_count_q + 10'd1;
					ph_n = dqar_pkg::PH_DONE;
				end
			end
			default: begin
			end
		endcase

		n = (byte_count_q < dqar_pkg::COUNT_SAT) ? byte_count_q + 10'd1 : byte_count_q;

		ans_ok = (type_n == dqar_pkg::TYPE_A) || (type_n == dqar_pkg::TYPE_ANY);
		sum = {1'b0, qend_n} + (ans_ok ? {6'd0, dqar_pkg::ANSWER_BYTES} : 11'd0);

		job.has_data = (ph != dqar_pkg::PH_DONE) && (ph != dqar_pkg::PH_STOP);
		job.data_off = byte_count_q[8:0];
		job.data_val = dval;
		job.has_end = end_of_message;
		job.qend = qend_n;
		job.ans = 1'b0;
		job.resp_len = 10'd0;
		if (n < 10'd12)
			job.status = dqar_pkg::ST_SHORT;
		else if (flt != dqar_pkg::ST_OK)
			job.status = flt;
		else if (ph_n == dqar_pkg::PH_LABEL)
			job.status = dqar_pkg::ST_BAD_NAME;
		else if (ph_n != dqar_pkg::PH_DONE)
			job.status = dqar_pkg::ST_TRUNCATED;
		else if (sum > 11'(dqar_pkg::MAX_PACKET_BYTES))
			job.status = dqar_pkg::ST_TOO_BIG;
		else begin
			job.status = dqar_pkg::ST_OK;
			job.ans = ans_ok;
			job.resp_len = sum[9:0];
		end

		push = accept && (job.has_data || end_of_message);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= 10'd0;
			phase_q <= dqar_pkg::PH_HEADER;
			label_left_q <= 6'd0;
			chn_q <= 1'b0;
			type_q <= 16'd0;
			qend_q <= 10'd0;
			fault_q <= dqar_pkg::ST_OK;
		end else if (accept) begin
			if (end_of_message) begin
				byte_count_q <= 10'd0;
				phase_q <= dqar_pkg::PH_HEADER;
				label_left_q <= 6'd0;
				chn_q <= 1'b0;
				type_q <= 16'd0;
				qend_q <= 10'd0;
				fault_q <= dqar_pkg::ST_OK;
			end else begin
				byte_count_q <= n;
				phase_q <= ph_n;
				label_left_q <= ll_n;
				chn_q <= chn_n;
				type_q <= type_n;
				qend_q <= qend_n;
				fault_q <= flt;
			end
		end
	end

endmodule

>>> rtl/dqar_queue.sv
// short job queue between front and back parts
// register array with read and write pointers; uses dqar_pkg
module dqar_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dqar_pkg::job_t   push_job,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output dqar_pkg::job_t   head
);

	dqar_pkg::job_t mem_q [dqar_pkg::QUEUE_DEPTH];
	logic [dqar_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [dqar_pkg::QCNT_W-1:0] count_q;

	assign full = (count_q == dqar_pkg::QCNT_W'(dqar_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> rtl/dqar_back.sv
// back part: steps through queued jobs and drives the output register
// data byte if any, then patch, optional answer record and done at message end; uses dqar_pkg
module dqar_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  dqar_pkg::job_t   head,
	output logic             pop,
	input  logic [31:0]      answer_address,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       kind,
	output logic [8:0]       byte_offset,
	output logic [7:0]       byte_value,
	output logic [2:0]       status,
	output logic [9:0]       response_length,
	output logic             final_res
);

	dqar_pkg::step_t step_q, cur_step, step_n;
	logic mid_q;
	logic [3:0] ans_idx_q;
	logic fire;
	logic [1:0] kind_n;
	logic [8:0] off_n;
	logic [7:0] val_n;

	always_comb begin
		cur_step = mid_q ? step_q :
			(head.has_data ? dqar_pkg::STEP_DATA : dqar_pkg::STEP_PATCH);
		fire = !empty && (!out_valid || !out_stall);
		pop = 1'b0;
		step_n = cur_step;
		kind_n = dqar_pkg::KIND_DATA;
		off_n = head.data_off;
		val_n = head.data_val;
		unique case (cur_step)
			dqar_pkg::STEP_DATA: begin
				if (head.has_end)
					step_n = dqar_pkg::STEP_PATCH;
				else
					pop = fire;
			end
			dqar_pkg::STEP_PATCH: begin
				kind_n = dqar_pkg::KIND_PATCH;
				off_n = dqar_pkg::PATCH_OFFSET;
				val_n = {7'd0, head.ans};
				step_n = head.ans ? dqar_pkg::STEP_ANS : dqar_pkg::STEP_DONE;
			end
			dqar_pkg::STEP_ANS: begin
				off_n = head.qend[8:0] + {5'd0, ans_idx_q};
				val_n = dqar_pkg::answer_byte(ans_idx_q, answer_address);
				if (ans_idx_q == 4'hF)
					step_n = dqar_pkg::STEP_DONE;
			end
			dqar_pkg::STEP_DONE: begin
				kind_n = dqar_pkg::KIND_DONE;
				off_n = 9'd0;
				val_n = 8'd0;
				pop = fire;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= dqar_pkg::STEP_DATA;
			mid_q <= 1'b0;
			ans_idx_q <= 4'd0;
			out_valid <= 1'b0;
		end else begin
			if (fire) begin
				out_valid <= 1'b1;
				mid_q <= !pop;
				step_q <= step_n;
				if (cur_step == dqar_pkg::STEP_ANS)
					ans_idx_q <= ans_idx_q + 4'd1;
				else
					ans_idx_q <= 4'd0;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			kind <= kind_n;
			byte_offset <= off_n;
			byte_value <= val_n;
			final_res <= (cur_step == dqar_pkg::STEP_DONE);
			status <= (cur_step == dqar_pkg::STEP_DONE) ? head.status : dqar_pkg::ST_OK;
			response_length <= (cur_step == dqar_pkg::STEP_DONE) ? head.resp_len : 10'd0;
		end
	end

endmodule

>>> rtl/dns_query_answer_rewriter_top.sv
// top level of the dns query answer rewriter
// holds the answer address register; uses dqar_pkg, dqar_front, dqar_queue, dqar_back
//
// input channel: one query byte per item (query_byte, end_of_message),
// in_valid / in_stall. output channel: result items (kind, byte_offset,
// byte_value, status, response_length, final_res), out_valid / out_stall.
// cfg_we with cfg_wdata writes the answer address; the user must write
// it only while idle, the block does not enforce this. the front parser
// takes one byte per cycle while the queue is not full; each byte gives
// at most one data item, via the job queue and the output register.
// the last byte of a message adds a patch, an optional 16-byte answer
// record and a done item; a 4-entry job queue absorbs this and in_stall
// rises only when the queue is full. a stalled output holds its item
// while the front keeps filling the queue. reset clears the parser, the
// queue pointers, the output valid flag and the answer address.
module dns_query_answer_rewriter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  query_byte,
	input  logic        end_of_message,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [8:0]  byte_offset,
	output logic [7:0]  byte_value,
	output logic [2:0]  status,
	output logic [9:0]  response_length,
	output logic        final_res
);

	logic [31:0] answer_address_q;
	logic push, full, pop, empty;
	dqar_pkg::job_t push_job, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			answer_address_q <= 32'd0;
		else if (cfg_we)
			answer_address_q <= cfg_wdata;
	end

	assign in_stall = full;

	dqar_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(in_valid && !full),
		.query_byte(query_byte),
		.end_of_message(end_of_message),
		.push(push),
		.job(push_job)
	);

	dqar_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.full(full),
		.pop(pop),
		.empty(empty),
		.head(head)
	);

	dqar_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.head(head),
		.pop(pop),
		.answer_address(answer_address_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.byte_offset(byte_offset),
		.byte_value(byte_value),
		.status(status),
		.response_length(response_length),
		.final_res(final_res)
	);

	a_final_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (final_res == (kind == dqar_pkg::KIND_DONE)))
		else $error("final flag and done kind disagree");

	a_data_no_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != dqar_pkg::KIND_DONE |-> status == dqar_pkg::ST_OK &&
			response_length == 10'd0)
		else $error("summary fields set on a non-done item");

	a_stall_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("queue filled without an accepted item");

	a_patch_followed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && kind == dqar_pkg::KIND_PATCH |=> out_valid)
		else $error("patch not followed by answer or done");

endmodule

>>> sim/tb.sv
// testbench for dns_query_answer_rewriter_top: streams directed and random dns queries
// through a byte-level predictor and checks every result item in order
// depends on rtl/dqar_pkg.sv and rtl/dns_query_answer_rewriter_top.sv
`timescale 1ns / 100ps

module tb;

	localparam int RUN_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 100;
	localparam logic [15:0] TYPE_AAAA = 16'd28;

	typedef struct {
		logic [7:0] b;
		logic last;
	} qbyte_t;

	typedef struct {
		logic [1:0] kind;
		logic [8:0] off;
		logic [7:0] val;
		logic [2:0] st;
		logic [9:0] len;
		logic fin;
	} resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] query_byte = 8'd0;
	logic end_of_message = 1'b0;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = 32'd0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] kind;
	logic [8:0] byte_offset;
	logic [7:0] byte_value;
	logic [2:0] status;
	logic [9:0] response_length;
	logic final_res;

	qbyte_t query_todo[$];
	resp_t resp_due[$];
	logic [7:0] msg[$];
	int n_queued = 0;
	int n_taken = 0;
	int errors = 0;
	int cycles = 0;
	logic took = 1'b0;
	logic steady = 1'b0;

	// predictor state
	logic [31:0] pr_addr = 32'd0;
	logic [9:0] pr_count = 10'd0;
	dqar_pkg::phase_t pr_phase = dqar_pkg::PH_HEADER;
	logic [5:0] pr_left = 6'd0;
	logic pr_high = 1'b0;
	logic [15:0] pr_type = 16'd0;
	logic [9:0] pr_qend = 10'd0;
	logic [2:0] pr_fault = dqar_pkg::ST_OK;

	dns_query_answer_rewriter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.query_byte(query_byte),
		.end_of_message(end_of_message),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.byte_offset(byte_offset),
		.byte_value(byte_value),
		.status(status),
		.response_length(response_length),
		.final_res(final_res)
	);

	always #2 clk = ~clk;

	always @(posedge clk) cycles <= cycles + 1;

	function automatic logic roll_idle();
		return !steady && ($urandom_range(99) < 22);
	endfunction

	function automatic void push_resp(input logic [1:0] k, input logic [8:0] off,
			input logic [7:0] val, input logic [2:0] st, input logic [9:0] len,
			input logic fin);
		resp_t r;
		r.kind = k;
		r.off = off;
		r.val = val;
		r.st = st;
		r.len = len;
		r.fin = fin;
		resp_due.push_back(r);
	endfunction

	task automatic rewrite_byte(input logic [7:0] b, input logic last);
		logic [9:0] c;
		logic [7:0] v;
		logic [2:0] st;
		logic ans;
		int tot;
		logic [7:0] rec [0:15];
		c = pr_count;
		if (pr_phase inside {dqar_pkg::PH_LEN, dqar_pkg::PH_LABEL, dqar_pkg::PH_TAIL} &&
				c >= dqar_pkg::MAX_PACKET_BYTES) begin
			pr_fault = dqar_pkg::ST_TOO_BIG;
			pr_phase = dqar_pkg::PH_STOP;
		end
		if (pr_phase <= dqar_pkg::PH_TAIL) begin
			v = b;
			if (c == 2)
				v = 8'h81;
			else if (c == 3)
				v = 8'h80;
			else if (c >= 6 && c < 12)
				v = 8'h00;
			push_resp(dqar_pkg::KIND_DATA, c[8:0], v, dqar_pkg::ST_OK, 10'd0, 1'b0);
		end
		case (pr_phase)
			dqar_pkg::PH_HEADER: begin
				if (c == 4)
					pr_high = (b != 8'd0);
				else if (c == 5) begin
					if (!pr_high && b == 8'd0) begin
						pr_fault = dqar_pkg::ST_NO_QUESTION;
						pr_phase = dqar_pkg::PH_STOP;
					end
				end else if (c == 11)
					pr_phase = dqar_pkg::PH_LEN;
			end
			dqar_pkg::PH_LEN: begin
				if (b == 8'd0) begin
					pr_left = 6'd4;
					pr_phase = dqar_pkg::PH_TAIL;
				end else if ((b & dqar_pkg::LEN_PTR_MASK) != 8'd0) begin
					pr_fault = dqar_pkg::ST_BAD_NAME;
					pr_phase = dqar_pkg::PH_STOP;
				end else begin
					pr_left = b[5:0];
					pr_phase = dqar_pkg::PH_LABEL;
				end
			end
			dqar_pkg::PH_LABEL: begin
				pr_left = pr_left - 6'd1;
				if (pr_left == 6'd0)
					pr_phase = dqar_pkg::PH_LEN;
			end
			dqar_pkg::PH_TAIL: begin
				if (pr_left == 6'd4)
					pr_type = {b, 8'h00};
				else if (pr_left == 6'd3)
					pr_type[7:0] = b;
				pr_left = pr_left - 6'd1;
				if (pr_left == 6'd0) begin
					pr_qend = c + 10'd1;
					pr_phase = dqar_pkg::PH_DONE;
				end
			end
			default: begin
			end
		endcase
		if (pr_count < dqar_pkg::COUNT_SAT)
			pr_count = pr_count + 10'd1;
		if (last) begin
			st = dqar_pkg::ST_OK;
			ans = 1'b0;
			tot = 0;
			if (pr_count < 12)
				st = dqar_pkg::ST_SHORT;
			else if (pr_fault != dqar_pkg::ST_OK)
				st = pr_fault;
			else if (pr_phase == dqar_pkg::PH_LABEL)
				st = dqar_pkg::ST_BAD_NAME;
			else if (pr_phase != dqar_pkg::PH_DONE)
				st = dqar_pkg::ST_TRUNCATED;
			else begin
				ans = (pr_type == dqar_pkg::TYPE_A || pr_type == dqar_pkg::TYPE_ANY);
				tot = pr_qend + (ans ? 16 : 0);
				if (tot > dqar_pkg::MAX_PACKET_BYTES) begin
					st = dqar_pkg::ST_TOO_BIG;
					ans = 1'b0;
					tot = 0;
				end
			end
			push_resp(dqar_pkg::KIND_PATCH, dqar_pkg::PATCH_OFFSET, {7'd0, ans},
				dqar_pkg::ST_OK, 10'd0, 1'b0);
			if (ans) begin
				rec = '{8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00,
					8'h00, 8'h3C, 8'h00, 8'h04,
					pr_addr[31:24], pr_addr[23:16], pr_addr[15:8], pr_addr[7:0]};
				for (int i = 0; i < 16; i++)
					push_resp(dqar_pkg::KIND_DATA, 9'(pr_qend + i), rec[i],
						dqar_pkg::ST_OK, 10'd0, 1'b0);
			end
			push_resp(dqar_pkg::KIND_DONE, 9'd0, 8'd0, st, 10'(tot), 1'b1);
			pr_count = 10'd0;
			pr_phase = dqar_pkg::PH_HEADER;
			pr_left = 6'd0;
			pr_high = 1'b0;
			pr_type = 16'd0;
			pr_qend = 10'd0;
			pr_fault = dqar_pkg::ST_OK;
		end
	endtask

	// input side: accept at the rising edge, drive at the falling edge
	always @(posedge clk) begin
		took <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			rewrite_byte(query_byte, end_of_message);
			n_taken++;
		end
	end

	always @(negedge clk) begin
		qbyte_t q;
		if (arst_n && (!in_valid || took)) begin
			if (query_todo.size() != 0 && !roll_idle()) begin
				q = query_todo.pop_front();
				in_valid <= 1'b1;
				query_byte <= q.b;
				end_of_message <= q.last;
			end else
				in_valid <= 1'b0;
		end
	end

	// output side
	always @(negedge clk) begin
		if (arst_n)
			out_stall <= roll_idle();
	end

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		resp_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (resp_due.size() == 0) begin
				$display("%0t: unexpected item kind %0d offset %0d value %0d", $time,
					kind, byte_offset, byte_value);
				errors++;
			end else begin
				e = resp_due.pop_front();
				check_field("kind", e.kind, kind);
				check_field("byte_offset", e.off, byte_offset);
				check_field("byte_value", e.val, byte_value);
				check_field("status", e.st, status);
				check_field("response_length", e.len, response_length);
				check_field("final_res", e.fin, final_res);
			end
		end
	end

	// message building
	task automatic flush_msg();
		qbyte_t q;
		for (int i = 0; i < msg.size(); i++) begin
			q.b = msg[i];
			q.last = (i == msg.size() - 1);
			query_todo.push_back(q);
		end
		n_queued += msg.size();
		msg.delete();
	endtask

	task automatic add_header(input logic [7:0] hi, input logic [7:0] lo);
		for (int i = 0; i < 4; i++)
			msg.push_back(8'($urandom));
		msg.push_back(hi);
		msg.push_back(lo);
		for (int i = 0; i < 6; i++)
			msg.push_back(8'($urandom));
	endtask

	// labels filling exactly total bytes, no terminator
	task automatic add_labels(input int total);
		int rem;
		int k;
		rem = total;
		while (rem > 0) begin
			k = rem - 1;
			if (k > 63)
				k = 63;
			if (rem - (k + 1) == 1)
				k = k - 1;
			msg.push_back(8'(k));
			for (int i = 0; i < k; i++)
				msg.push_back(8'($urandom));
			rem -= k + 1;
		end
	endtask

	task automatic add_question_end(input logic [15:0] t);
		msg.push_back(8'h00);
		msg.push_back(t[15:8]);
		msg.push_back(t[7:0]);
		msg.push_back(8'h00);
		msg.push_back(8'h01);
	endtask

	task automatic rand_msg();
		int r;
		int nlab;
		int len;
		logic [7:0] hi;
		logic [15:0] t;
		r = $urandom_range(99);
		if (r < 8) begin
			len = $urandom_range(1, 30);
			for (int i = 0; i < len; i++)
				msg.push_back(8'($urandom));
		end else begin
			if (r < 12)
				add_header(8'd0, 8'd0);
			else begin
				hi = ($urandom_range(3) == 0) ? 8'($urandom) : 8'd0;
				add_header(hi, (hi == 8'd0) ? 8'($urandom_range(1, 255)) : 8'($urandom));
			end
			nlab = $urandom_range(0, 4);
			for (int j = 0; j < nlab; j++) begin
				len = ($urandom_range(19) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 8);
				if ($urandom_range(39) == 0)
					msg.push_back({2'($urandom_range(1, 3)), 6'($urandom)});
				else
					msg.push_back(8'(len));
				for (int i = 0; i < len; i++)
					msg.push_back(8'($urandom));
			end
			case ($urandom_range(3))
				0: t = dqar_pkg::TYPE_A;
				1: t = dqar_pkg::TYPE_ANY;
				2: t = TYPE_AAAA;
				default: t = 16'($urandom);
			endcase
			msg.push_back(8'h00);
			msg.push_back(t[15:8]);
			msg.push_back(t[7:0]);
			msg.push_back(($urandom_range(3) == 0) ? 8'($urandom) : 8'h00);
			msg.push_back(($urandom_range(3) == 0) ? 8'($urandom) : 8'h01);
			len = $urandom_range(0, 6);
			for (int i = 0; i < len; i++)
				msg.push_back(8'($urandom));
			if ($urandom_range(9) == 0) begin
				len = $urandom_range(1, msg.size());
				while (msg.size() > len)
					void'(msg.pop_back());
			end
		end
		flush_msg();
	endtask

	task automatic drain();
		while (n_taken != n_queued || resp_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_address(input logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		pr_addr = v;
	endtask

	task automatic rand_phase(input int min_bytes, input int min_msgs);
		int start;
		int cnt;
		start = n_queued;
		cnt = 0;
		while (n_queued - start < min_bytes || cnt < min_msgs) begin
			rand_msg();
			cnt++;
		end
		drain();
	endtask

	initial begin
		wait (cycles >= RUN_LIMIT);
		$display("dns_query_answer_rewriter_top test failed");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, address still at its reset value
		msg.push_back(8'hFF);
		flush_msg();
		for (int i = 0; i < 11; i++)
			msg.push_back((i == 4 || i == 5) ? 8'h00 : 8'($urandom));
		flush_msg();
		add_header(8'd0, 8'd1);
		flush_msg();
		add_header(8'd0, 8'd0);
		add_labels(4);
		add_question_end(dqar_pkg::TYPE_A);
		flush_msg();
		msg = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 8'h01, 8'hFF};
		add_question_end(dqar_pkg::TYPE_A);
		flush_msg();
		add_header(8'd0, 8'd1);
		add_labels(64);
		add_question_end(dqar_pkg::TYPE_ANY);
		for (int i = 0; i < 5; i++)
			msg.push_back(8'($urandom));
		flush_msg();
		add_header(8'd0, 8'd1);
		add_labels(7);
		add_question_end(TYPE_AAAA);
		flush_msg();
		add_header(8'd0, 8'd1);
		add_labels(3);
		add_question_end(16'h0100);
		flush_msg();
		add_header(8'd0, 8'd1);
		add_question_end(dqar_pkg::TYPE_A);
		flush_msg();
		add_header(8'd0, 8'd1);
		msg.push_back(8'hC0);
		msg.push_back(8'h0C);
		add_question_end(dqar_pkg::TYPE_A);
		flush_msg();
		add_header(8'd0, 8'd1);
		add_labels(3);
		msg.push_back(8'h40);
		add_question_end(dqar_pkg::TYPE_A);
		flush_msg();
		add_header(8'd0, 8'd1);
		msg.push_back(8'h80);
		msg.push_back(8'h01);
		flush_msg();
		add_header(8'd0, 8'd1);
		msg.push_back(8'd5);
		msg.push_back(8'h61);
		msg.push_back(8'h62);
		flush_msg();
		add_header(8'd0, 8'd1);
		add_labels(6);
		flush_msg();
		add_header(8'd0, 8'd1);
		add_labels(2);
		msg.push_back(8'h00);
		msg.push_back(8'h00);
		flush_msg();
		add_header(8'd0, 8'd1);
		add_labels(5);
		add_question_end(dqar_pkg::TYPE_ANY);
		flush_msg();
		drain();

		write_address(32'hFFFFFFFF);
		rand_phase(20, 1);
		write_address(32'h00000000);
		steady = 1'b1;
		rand_phase(45, 2);
		steady = 1'b0;
		write_address($urandom);
		rand_phase(20, 1);

		if (errors == 0)
			$display("dns_query_answer_rewriter_top test passed");
		else
			$display("dns_query_answer_rewriter_top test failed");
		$finish;
	end

endmodule
